@@ rtl/egcd_pkg.sv @@
// Shared types for the extended Euclid GCD block.
`default_nettype none
package egcd_pkg;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_DIV    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } rnd_status_t;

endpackage
`default_nettype wire

@@ rtl/egcd_round.sv @@
// Bit-serial divider with quotient-times-coefficient accumulators for one Euclid round.
`default_nettype none
module egcd_round
  import egcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [WIDTH-2:0]   dividend_i,
  input  wire logic [WIDTH-2:0]   divisor_i,
  input  wire logic [WIDTH-1:0]   mul_s_i,
  input  wire logic [WIDTH-1:0]   mul_t_i,
  output rnd_status_t             status_o,
  output logic      [WIDTH-2:0]   rem_o,
  output logic      [WIDTH-1:0]   prod_s_o,
  output logic      [WIDTH-1:0]   prod_t_o
);

  localparam int N     = WIDTH - 1;
  localparam int CNT_W = $clog2(N);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [N-1:0]     quo_q, quo_d;
  logic [N-1:0]     rem_q, rem_d;
  logic [WIDTH-1:0] acc_s_q, acc_s_d;
  logic [WIDTH-1:0] acc_t_q, acc_t_d;
  logic [N+1:0]     diff;
  logic             ge;

  assign diff = {1'b0, rem_q, quo_q[N-1]} - {2'b00, divisor_i};
  assign ge   = ~diff[N+1];

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    acc_s_d = acc_s_q;
    acc_t_d = acc_t_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = CNT_W'(N - 1);
      quo_d   = dividend_i;
      rem_d   = '0;
      acc_s_d = '0;
      acc_t_d = '0;
    end else if (busy_q) begin
      quo_d   = {quo_q[N-2:0], ge};
      rem_d   = ge ? diff[N-1:0] : {rem_q[N-2:0], quo_q[N-1]};
      acc_s_d = {acc_s_q[WIDTH-2:0], 1'b0} + (ge ? mul_s_i : '0);
      acc_t_d = {acc_t_q[WIDTH-2:0], 1'b0} + (ge ? mul_t_i : '0);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    acc_s_q <= acc_s_d;
    acc_t_q <= acc_t_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;
  assign prod_s_o      = acc_s_q;
  assign prod_t_o      = acc_t_q;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q) else $error("round unit did not go busy");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("done without a finished round");
  a_start_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> divisor_i != '0) else $error("round started with zero divisor");

endmodule
`default_nettype wire

@@ rtl/extended_euclid_gcd_top.sv @@
// Top level of the extended Euclid GCD block: stream ports, sequencer and Bezout registers.
//
// One item carries operands a and b and yields gcd(a,b) with coefficients s and t such that
// s*a + t*b = gcd; b = 0 gives s = 1, t = 0. Each Euclid round runs a bit-serial divider that
// retires one quotient bit per cycle while the quotient-times-coefficient products build up
// alongside. An item runs as many rounds as Euclid's algorithm needs for its operands.
// The input is not ready while an item is in work; a finished result sits in an output
// register, so the next item is taken while it waits.
`default_nettype none
module extended_euclid_gcd_top
  import egcd_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // operand_a, operand_b, zero fill
  input  wire logic [((2*WIDTH-2)+7)/8*8-1:0]        s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // gcd_value, coef_s, coef_t, zero fill
  output logic      [((3*WIDTH-1)+7)/8*8-1:0]        m_axis_tdata
);

  localparam int N = WIDTH - 1;

  state_e           state_q, state_d;
  logic [N-1:0]     x_q, y_q;
  logic [WIDTH-1:0] sc_q, sn_q, tc_q, tn_q;
  logic [N-1:0]     gcd_q;
  logic [WIDTH-1:0] s_out_q, t_out_q;
  logic             m_valid_q, m_valid_d;
  logic             in_fire, out_load, rnd_start;
  rnd_status_t      rnd_status;
  logic [N-1:0]     rnd_rem;
  logic [WIDTH-1:0] prod_s, prod_t;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign rnd_start     = (state_q == ST_CHECK) && (y_q != '0);
  assign out_load      = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);

  egcd_round #(.WIDTH(WIDTH)) u_round (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (rnd_start),
    .dividend_i (x_q),
    .divisor_i  (y_q),
    .mul_s_i    (sn_q),
    .mul_t_i    (tn_q),
    .status_o   (rnd_status),
    .rem_o      (rnd_rem),
    .prod_s_o   (prod_s),
    .prod_t_o   (prod_t)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_fire) state_d = ST_CHECK;
      ST_CHECK:  state_d = (y_q == '0) ? ST_FINISH : ST_DIV;
      ST_DIV:    if (rnd_status.done) state_d = ST_CHECK;
      ST_FINISH: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_q  <= s_axis_tdata[N-1:0];
      y_q  <= s_axis_tdata[2*N-1:N];
      sc_q <= WIDTH'(1);
      sn_q <= '0;
      tc_q <= '0;
      tn_q <= WIDTH'(1);
    end else if (state_q == ST_DIV && rnd_status.done) begin
      x_q  <= y_q;
      y_q  <= rnd_rem;
      sc_q <= sn_q;
      sn_q <= sc_q - prod_s;
      tc_q <= tn_q;
      tn_q <= tc_q - prod_t;
    end
    if (out_load) begin
      gcd_q   <= x_q;
      s_out_q <= sc_q;
      t_out_q <= tc_q;
    end
  end

  always_comb begin
    m_axis_tdata              = '0;
    m_axis_tdata[N-1:0]       = gcd_q;
    m_axis_tdata[N +: WIDTH]  = s_out_q;
    m_axis_tdata[2*WIDTH-1 +: WIDTH] = t_out_q;
  end
  assign m_axis_tvalid = m_valid_q;

  a_round_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && rnd_status.done) |=> state_q == ST_CHECK)
    else $error("sequencer missed end of round");
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");
  a_idle_round : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !rnd_status.busy)
    else $error("input ready while a round is running");

endmodule
`default_nettype wire
